[sv/calendar_clock_with_date_rollover_macros.svh]
// ----------------------------------------------------------------------------
// Calendar clock assertion macros
// Shared assertion shorthands for the calendar clock checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_WITH_DATE_ROLLOVER_MACROS_SVH
`define CALENDAR_CLOCK_WITH_DATE_ROLLOVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTCC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar clock check failed");

// Next-cycle implication, disabled during reset.
`define RTCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar clock check failed");

`endif

[sv/rtcc_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar clock package
// Types, constants and calendar helper functions shared by the calendar clock.
// ----------------------------------------------------------------------------
package rtcc_pkg;

   // Channel widths.
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;

   // Calendar limits.
   localparam logic [15:0] MIN_YEAR    = 16'd2000;
   localparam logic [15:0] MAX_YEAR    = 16'd65535;
   localparam logic [3:0]  LAST_MONTH  = 4'd12;
   localparam logic [4:0]  LAST_HOUR   = 5'd23;
   localparam logic [5:0]  LAST_MINUTE = 6'd59;
   localparam logic [5:0]  LAST_SECOND = 6'd59;

   // Reset date.
   localparam logic [15:0] RESET_YEAR  = 16'd2026;
   localparam logic [3:0]  RESET_MONTH = 4'd8;
   localparam logic [4:0]  RESET_DAY   = 5'd16;

   // Divisibility by 25: multiply by the inverse of 25 modulo 2^16 and
   // compare against floor(65535 / 25).
   localparam logic [15:0] INV25       = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_SET  = 2'd1,
      CMD_READ = 2'd2
   } rtcc_cmd_type;

   // Current date and time; year sits in the lowest bits.
   typedef struct packed {
      logic        wall;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
   } rtcc_time_type;

   // Raw set fields; year sits in the lowest bits.
   typedef struct packed {
      logic [7:0]  second;
      logic [7:0]  minute;
      logic [7:0]  hour;
      logic [7:0]  day;
      logic [7:0]  month;
      logic [15:0] year;
   } rtcc_set_type;

   localparam rtcc_time_type TIME_RESET = '{
      wall: 1'b0, second: 6'd0, minute: 6'd0, hour: 5'd0,
      day: RESET_DAY, month: RESET_MONTH, year: RESET_YEAR};

   // Gregorian leap rule. Divisible by 100 means divisible by 4 and 25,
   // divisible by 400 means divisible by 16 and 25.
   function automatic logic is_leap(input logic [15:0] y);
      logic [15:0] prod;
      logic        div25;
      prod  = y * INV25;
      div25 = (prod <= DIV25_LIMIT);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   // Length of a month in days; month is expected in 1..12.
   function automatic logic [4:0] days_in_month(input logic [15:0] y,
                                                input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2: begin
            len = is_leap(y) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

[sv/rtcc_next.sv]
// ----------------------------------------------------------------------------
// Calendar clock next-state logic
// Computes the date and time after one command: tick, set or read.
// ----------------------------------------------------------------------------
module rtcc_next (
   input  rtcc_pkg::rtcc_cmd_type  cmd,
   input  rtcc_pkg::rtcc_set_type   set_fields,
   input  rtcc_pkg::rtcc_time_type  cur,
   output rtcc_pkg::rtcc_time_type  nxt
);
   import rtcc_pkg::*;

   logic [15:0] set_year;
   logic [3:0]  set_month;
   logic [4:0]  set_dim;
   logic [4:0]  cur_dim;
   logic        sec_wrap;
   logic        min_wrap;
   logic        hour_wrap;

   // Clamp the set fields.
   always_comb begin
      set_year  = (set_fields.year < MIN_YEAR) ? MIN_YEAR : set_fields.year;
      set_month = ((set_fields.month >= 8'd1) && (set_fields.month <= 8'd12)) ?
                  set_fields.month[3:0] : 4'd1;
      set_dim   = days_in_month(set_year, set_month);
   end

   // Carry chain of the running time.
   always_comb begin
      cur_dim   = days_in_month(cur.year, cur.month);
      sec_wrap  = (cur.second == LAST_SECOND);
      min_wrap  = sec_wrap && (cur.minute == LAST_MINUTE);
      hour_wrap = min_wrap && (cur.hour == LAST_HOUR);
   end

   // Select the new state by command.
   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_TICK: begin
            nxt.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
            if (sec_wrap) begin
               nxt.minute = (cur.minute == LAST_MINUTE) ? 6'd0 : cur.minute + 6'd1;
            end
            if (min_wrap) begin
               nxt.hour = (cur.hour == LAST_HOUR) ? 5'd0 : cur.hour + 5'd1;
            end
            if (hour_wrap) begin
               if (cur.day >= cur_dim) begin
                  nxt.day = 5'd1;
                  if (cur.month >= LAST_MONTH) begin
                     nxt.month = 4'd1;
                     if (cur.year != MAX_YEAR) begin
                        nxt.year = cur.year + 16'd1;
                     end
                  end else begin
                     nxt.month = cur.month + 4'd1;
                  end
               end else begin
                  nxt.day = cur.day + 5'd1;
               end
            end
         end
         CMD_SET: begin
            nxt.year   = set_year;
            nxt.month  = set_month;
            nxt.day    = ((set_fields.day != 8'd0) &&
                          (set_fields.day <= {3'd0, set_dim})) ?
                         set_fields.day[4:0] : 5'd1;
            nxt.hour   = (set_fields.hour > {3'd0, LAST_HOUR}) ?
                         5'd0 : set_fields.hour[4:0];
            nxt.minute = (set_fields.minute > {2'd0, LAST_MINUTE}) ?
                         6'd0 : set_fields.minute[5:0];
            nxt.second = (set_fields.second > {2'd0, LAST_SECOND}) ?
                         6'd0 : set_fields.second[5:0];
            nxt.wall   = 1'b1;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

[sv/calendar_clock_with_date_rollover.sv]
// ----------------------------------------------------------------------------
// Calendar clock with date rollover
// Pipeline: a command waits in the input register until the result register is
// free or drained; its result is then registered there and transfers out.
// Throughput: one command per cycle; a stalled result holds the input register,
// so req_tready drops only while both registers are full and the result waits.
// Reset: synchronous; the clock restarts at 2026-08-16 00:00:00, not wall-clock.
// ----------------------------------------------------------------------------
module calendar_clock_with_date_rollover (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // set_year, set_month, set_day, set_hour, set_minute, set_second
   input  logic [rtcc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic [rtcc_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
   // wall_valid, zero fill
   output logic [rtcc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rtcc_pkg::*;

   logic          in_valid_ff;
   rtcc_cmd_type  cmd_ff;
   rtcc_set_type  set_ff;
   rtcc_time_type time_ff;
   rtcc_time_type time_in;
   logic          rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic          advance;

   // The held command moves on when the result register is free or drained.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= rtcc_cmd_type'(req_tuser);
         set_ff <= rtcc_set_type'(req_tdata);
      end
   end

   rtcc_next u_next (
      .cmd        (cmd_ff),
      .set_fields (set_ff),
      .cur        (time_ff),
      .nxt        (time_in)
   );

   // Clock and calendar state.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= TIME_RESET;
      end else if (advance) begin
         time_ff <= time_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {{(RSP_DATA_W - $bits(rtcc_time_type)){1'b0}}, time_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/rtcc_checker.sv]
// ----------------------------------------------------------------------------
// Calendar clock checker
// Port-level checks on the results of the calendar clock.
// ----------------------------------------------------------------------------
`include "calendar_clock_with_date_rollover_macros.svh"

module rtcc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rtcc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rtcc_pkg::*;

   rtcc_time_type rsp_time;

   assign rsp_time = rtcc_time_type'(rsp_tdata[$bits(rtcc_time_type)-1:0]);

   // A stalled result keeps its value.
   `RTCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The date is always a legal calendar date.
   `RTCC_ASSERT_NOW(a_date_legal, clock, reset, rsp_tvalid, (rsp_time.year >= MIN_YEAR) && (rsp_time.month >= 4'd1) && (rsp_time.month <= LAST_MONTH) && (rsp_time.day >= 5'd1) && (rsp_time.day <= days_in_month(rsp_time.year, rsp_time.month)))

   // The time of day is always legal.
   `RTCC_ASSERT_NOW(a_time_legal, clock, reset, rsp_tvalid, (rsp_time.hour <= LAST_HOUR) && (rsp_time.minute <= LAST_MINUTE) && (rsp_time.second <= LAST_SECOND))

   // The fill bits above the packed fields stay zero.
   `RTCC_ASSERT_NOW(a_fill_zero, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:$bits(rtcc_time_type)] == '0)

endmodule

bind calendar_clock_with_date_rollover rtcc_checker u_rtcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Calendar clock testbench
// Drives tick, set, read and unused commands into the calendar clock with
// random gaps on the command side and random stalls on the result side. A
// local calendar model predicts each returned date and time, and a monitor
// compares every result field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rtcc_pkg::*;

   // The fourth command code is unused and acts as a plain read.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned RANDOM_ITEMS  = 800;
   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned TAIL_CYCLES   = 8;
   localparam int unsigned MAX_PRINTED   = 40;

   // One command as it goes into the block.
   typedef struct {
      logic [1:0]   cmd;
      rtcc_set_type fields;
   } clock_cmd_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // set_year, set_month, set_day, set_hour, set_minute, set_second
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // command
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
   // wall_valid, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   calendar_clock_with_date_rollover dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Commands waiting to be sent and dates the block still owes us.
   clock_cmd_t    pending_cmds[$];
   rtcc_time_type expected_times[$];
   clock_cmd_t    cmd_in_flight;

   int unsigned fail_count      = 0;
   int unsigned cmds_accepted   = 0;
   int unsigned cmds_total      = 0;
   int unsigned results_seen    = 0;
   int unsigned set_count       = 0;
   int unsigned tick_count      = 0;
   int unsigned day_rollovers   = 0;
   int unsigned year_holds      = 0;
   int unsigned idle_cycles     = 0;
   int unsigned cycle_count     = 0;
   int unsigned req_gap         = 0;
   int unsigned rsp_stall       = 0;

   // Local copy of the calendar state.
   logic [16:0] cal_secs;
   logic [15:0] cal_year;
   logic [3:0]  cal_month;
   logic [4:0]  cal_day;
   logic        cal_wall;

   int unsigned month_len[1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_for_month(input int unsigned y, input int unsigned m);
      if (m < 1 || m > 12) begin
         return 31;
      end
      if (m == 2 && leap_year(y)) begin
         return 29;
      end
      return month_len[m];
   endfunction

   // Mostly short gaps, a few long ones, and whole stretches with none at all.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cycle_count[9:8] == 2'b00 || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Midnight carry: advance the date by one day with month and year rollover.
   task automatic advance_date();
      day_rollovers++;
      if (cal_day < days_for_month(cal_year, cal_month)) begin
         cal_day = cal_day + 1'b1;
      end else begin
         cal_day = 5'd1;
         if (cal_month < 4'd12) begin
            cal_month = cal_month + 1'b1;
         end else begin
            cal_month = 4'd1;
            if (cal_year == MAX_YEAR) begin
               year_holds++;
            end else begin
               cal_year = cal_year + 1'b1;
            end
         end
      end
   endtask

   // Apply one accepted command to the local calendar and queue the date it returns.
   task automatic apply_command(input clock_cmd_t c);
      int unsigned   y, mo, d, h, mi, s;
      rtcc_time_type want;
      if (c.cmd == CMD_TICK) begin
         tick_count++;
         if (cal_secs + 1 >= SECS_PER_DAY) begin
            cal_secs = '0;
            advance_date();
         end else begin
            cal_secs = cal_secs + 1'b1;
         end
      end else if (c.cmd == CMD_SET) begin
         set_count++;
         y  = c.fields.year;
         mo = c.fields.month;
         d  = c.fields.day;
         h  = c.fields.hour;
         mi = c.fields.minute;
         s  = c.fields.second;
         if (y < MIN_YEAR) y = MIN_YEAR;
         if (mo < 1 || mo > 12) mo = 1;
         // The day is checked against the already clamped year and month.
         if (d < 1 || d > days_for_month(y, mo)) d = 1;
         if (h > 23) h = 0;
         if (mi > 59) mi = 0;
         if (s > 59) s = 0;
         cal_year  = y[15:0];
         cal_month = mo[3:0];
         cal_day   = d[4:0];
         cal_secs  = 17'(h * SECS_PER_HOUR + mi * SECS_PER_MIN + s);
         cal_wall  = 1'b1;
      end
      want.year   = cal_year;
      want.month  = cal_month;
      want.day    = cal_day;
      want.hour   = 5'(cal_secs / SECS_PER_HOUR);
      want.minute = 6'((cal_secs % SECS_PER_HOUR) / SECS_PER_MIN);
      want.second = 6'(cal_secs % SECS_PER_MIN);
      want.wall   = cal_wall;
      expected_times.push_back(want);
   endtask

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endtask

   // Compare one returned date and time with the oldest prediction.
   task automatic check_result(input logic [RSP_DATA_W-1:0] data);
      rtcc_time_type got, want;
      got = data[$bits(rtcc_time_type)-1:0];
      if (expected_times.size() == 0) begin
         report_mismatch($sformatf("result %0h arrived with nothing expected", data));
         return;
      end
      want = expected_times.pop_front();
      if (got.year !== want.year)
         report_mismatch($sformatf("result %0d year %0d, want %0d",
                                   results_seen, got.year, want.year));
      if (got.month !== want.month)
         report_mismatch($sformatf("result %0d month %0d, want %0d",
                                   results_seen, got.month, want.month));
      if (got.day !== want.day)
         report_mismatch($sformatf("result %0d day %0d, want %0d",
                                   results_seen, got.day, want.day));
      if (got.hour !== want.hour)
         report_mismatch($sformatf("result %0d hour %0d, want %0d",
                                   results_seen, got.hour, want.hour));
      if (got.minute !== want.minute)
         report_mismatch($sformatf("result %0d minute %0d, want %0d",
                                   results_seen, got.minute, want.minute));
      if (got.second !== want.second)
         report_mismatch($sformatf("result %0d second %0d, want %0d",
                                   results_seen, got.second, want.second));
      if (got.wall !== want.wall)
         report_mismatch($sformatf("result %0d wall flag %0b, want %0b",
                                   results_seen, got.wall, want.wall));
      if (data[RSP_DATA_W-1:$bits(rtcc_time_type)] !== '0)
         report_mismatch($sformatf("result %0d fill bits %0h, want zero",
                                   results_seen, data[RSP_DATA_W-1:$bits(rtcc_time_type)]));
      results_seen++;
   endtask

   // Command driver: holds each transfer until it is taken, then inserts a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            apply_command(cmd_in_flight);
            cmds_accepted++;
         end
         if (req_gap != 0 || pending_cmds.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap != 0) req_gap <= req_gap - 1;
         end else begin
            cmd_in_flight = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= cmd_in_flight.fields;
            req_tuser  <= cmd_in_flight.cmd;
            req_gap    <= pick_gap();
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
         end
         if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall  <= pick_gap();
         end
      end
   end

   // Watchdog: ends the run when neither side has moved for too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_item(input logic [1:0] cmd, input logic [15:0] y,
                           input logic [7:0] mo, input logic [7:0] d,
                           input logic [7:0] h, input logic [7:0] mi,
                           input logic [7:0] s);
      clock_cmd_t c;
      c.cmd           = cmd;
      c.fields.year   = y;
      c.fields.month  = mo;
      c.fields.day    = d;
      c.fields.hour   = h;
      c.fields.minute = mi;
      c.fields.second = s;
      pending_cmds.push_back(c);
   endtask

   // A command whose set fields carry random junk, which the block must ignore unless it is a set.
   task automatic add_junk(input logic [1:0] cmd);
      add_item(cmd, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom));
   endtask

   // Set a date, usually close to midnight near a month or year end, then send 1 to 16 ticks.
   task automatic add_rollover_run();
      int unsigned y, mo, d, r, ticks;
      r = $urandom_range(0, 9);
      case (r)
         0: y = 65535;
         1: y = $urandom_range(0, 1999);
         2: y = $urandom_range(0, 65535);
         3: y = $urandom_range(0, 3) * 100 + 2000;
         default: y = $urandom_range(2000, 2500);
      endcase
      r = $urandom_range(0, 9);
      case (r)
         0: mo = $urandom_range(0, 255);
         1, 2, 3: mo = 12;
         4, 5: mo = 2;
         default: mo = $urandom_range(1, 12);
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) begin
         d = $urandom_range(0, 255);
      end else if (r < 7) begin
         d = days_for_month(y < MIN_YEAR ? MIN_YEAR : y, (mo < 1 || mo > 12) ? 1 : mo);
      end else if (r == 7) begin
         d = 29;
      end else begin
         d = $urandom_range(1, 28);
      end
      if ($urandom_range(0, 7) == 0) begin
         add_item(CMD_SET, y[15:0], mo[7:0], d[7:0], 8'($urandom), 8'($urandom),
                  8'($urandom));
      end else begin
         add_item(CMD_SET, y[15:0], mo[7:0], d[7:0], 8'd23, 8'd59,
                  8'($urandom_range(45, 59)));
      end
      ticks = $urandom_range(1, 16);
      repeat (ticks) add_junk(CMD_TICK);
      if ($urandom_range(0, 2) == 0) add_junk(CMD_READ);
   endtask

   initial begin
      int unsigned r;

      // Directed commands: reset state, field extremes and calendar corners.
      add_junk(CMD_READ);
      add_item(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_item(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      add_item(CMD_SET, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_item(CMD_SET, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // Year saturation on the last day of the last year.
      add_item(CMD_SET, 16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      // February 29 kept in a leap year and carried into March.
      add_item(CMD_SET, 16'd2024, 8'd2, 8'd29, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      // Century years: 2100 is not a leap year, 2000 is.
      add_item(CMD_SET, 16'd2100, 8'd2, 8'd29, 8'd12, 8'd30, 8'd30);
      add_item(CMD_SET, 16'd2000, 8'd2, 8'd29, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      add_item(CMD_SET, 16'd2023, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      add_item(CMD_SET, 16'd2024, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      // Day beyond a 30-day month, then a 30-day month end.
      add_item(CMD_SET, 16'd2025, 8'd4, 8'd31, 8'd1, 8'd2, 8'd3);
      add_item(CMD_SET, 16'd2025, 8'd4, 8'd30, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      add_item(CMD_SET, 16'd2099, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59);
      add_junk(CMD_TICK);
      // Every time field just out of range.
      add_item(CMD_SET, 16'd1999, 8'd13, 8'd32, 8'd24, 8'd60, 8'd60);
      add_item(CMD_SET, 16'd2026, 8'd6, 8'd15, 8'd23, 8'd59, 8'd58);
      add_junk(CMD_TICK);
      add_junk(CMD_TICK);

      // Random part: mostly rollover runs, with raw sets, reads, unused commands and stray ticks.
      while (pending_cmds.size() < RANDOM_ITEMS + 25) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            add_rollover_run();
         end else if (r < 85) begin
            add_junk(CMD_SET);
         end else if (r < 90) begin
            add_junk(CMD_READ);
         end else if (r < 95) begin
            add_junk(CMD_UNUSED);
         end else begin
            add_junk(CMD_TICK);
         end
      end
      cmds_total = pending_cmds.size();

      // Reset values of the local calendar.
      cal_secs  = '0;
      cal_year  = RESET_YEAR;
      cal_month = RESET_MONTH;
      cal_day   = RESET_DAY;
      cal_wall  = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every command to be taken and every result to come back.
      do @(posedge clock); while (cmds_accepted != cmds_total || expected_times.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d commands (%0d sets, %0d ticks), checked %0d results.",
               cmds_total, set_count, tick_count, results_seen);
      $display("Crossed midnight %0d times, %0d of them holding the year at its maximum.",
               day_rollovers, year_holds);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/rtcc_pkg.sv
sv/rtcc_next.sv
sv/calendar_clock_with_date_rollover.sv
sv/rtcc_checker.sv
tb/sv/tb_top.sv
